// ----- src/ipt_pkg.sv -----
package ipt_pkg;

  // Character codes the tokenizer recognizes.
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Reset values of the delimiter registers.
  localparam logic [7:0] PARAM_DELIM_RST  = 8'd44;
  localparam logic [7:0] RECORD_DELIM_RST = 8'd59;

  // Saturated count value, binary and packed decimal.
  localparam logic [15:0] COUNT_SAT = 16'hFFFF;
  localparam logic [19:0] BCD_SAT   = 20'h65535;

  // Configuration register indexes.
  typedef enum logic {
    REG_PARAM_DELIM  = 1'b0,
    REG_RECORD_DELIM = 1'b1
  } cfg_reg_t;

  // Request from the parser to the emitter. A burst streams stored characters;
  // otherwise a single result with no character is produced.
  typedef struct packed {
    logic burst;
    logic token_done;
    logic data_done;
    logic trunc;
  } emit_ctl_t;

endpackage

// ----- src/ipt_token_store.sv -----
module ipt_token_store import ipt_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/ipt_emit.sv -----
module ipt_emit import ipt_pkg::*; #(
  parameter int AW = 5,
  parameter int LW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  emit_ctl_t     req_ctl,
  input  logic [LW-1:0] req_len,
  output logic          busy,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    token_char,
  output logic          char_present,
  output logic          token_done,
  output logic          data_done,
  output logic          truncated
);

  logic          active;
  logic [AW-1:0] rd_idx;
  logic [LW-1:0] left;
  logic          burst_dd;
  logic          burst_trunc;
  logic          pend;
  logic          pend_last;
  logic          dpend;
  emit_ctl_t     dres;
  logic          out_free;
  logic          issue;
  logic          load_mem;
  logic          load_dir;

  // The output register frees up when it is empty or its beat is taken.
  assign out_free = !out_valid || !out_stall;
  assign issue    = active && (!pend || out_free);
  assign load_mem = pend && out_free;
  assign load_dir = dpend && out_free;
  assign rd_en    = issue;
  assign rd_addr  = rd_idx;
  assign busy     = active || pend || dpend;

  // Read sequencer and pending-data tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= 1'b0;
      dpend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_valid) begin
        if (req_ctl.burst) begin
          active <= 1'b1;
        end else begin
          dpend <= 1'b1;
        end
      end
      if (issue) begin
        if (left == LW'(1)) begin
          active <= 1'b0;
        end
        pend <= 1'b1;
      end else if (load_mem) begin
        pend <= 1'b0;
      end
      if (load_dir) begin
        dpend <= 1'b0;
      end
      if (load_mem || load_dir) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Burst bookkeeping and the single-result holding register.
  always_ff @(posedge clk) begin
    if (req_valid) begin
      rd_idx      <= '0;
      left        <= req_len;
      burst_dd    <= req_ctl.data_done;
      burst_trunc <= req_ctl.trunc;
      dres        <= req_ctl;
    end
    if (issue) begin
      rd_idx    <= rd_idx + AW'(1);
      left      <= left - LW'(1);
      pend_last <= (left == LW'(1));
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load_mem) begin
      token_char   <= rd_data;
      char_present <= 1'b1;
      token_done   <= pend_last;
      data_done    <= burst_dd && pend_last;
      truncated    <= burst_trunc;
    end else if (load_dir) begin
      token_char   <= '0;
      char_present <= 1'b0;
      token_done   <= dres.token_done;
      data_done    <= dres.data_done;
      truncated    <= dres.trunc;
    end
  end

endmodule

// ----- src/ipt_parser.sv -----
module ipt_parser import ipt_pkg::*; #(
  parameter int TOKEN_BYTES = 32,
  parameter int AW          = 5,
  parameter int LW          = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    param_delim,
  input  logic [7:0]    record_delim,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char,
  input  logic [15:0]   chars_after,
  input  logic          final_char,
  input  logic          emit_busy,
  output logic          req_valid,
  output emit_ctl_t     req_ctl,
  output logic [LW-1:0] req_len,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  localparam logic [LW-1:0] TB_LEN = LW'(TOKEN_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIT  = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [LW-1:0] tok_len, tok_len_next;
  logic          ovf, ovf_next;
  logic          dig_only, dig_only_next;
  logic [15:0]   cnt, cnt_next;
  logic [19:0]   bcd, bcd_next;
  logic          in_lit, in_lit_next;
  logic [15:0]   lit_left, lit_left_next;
  logic          halted, halted_next;
  logic [19:0]   seq_digits, seq_digits_next;
  logic [2:0]    seq_ndig, seq_ndig_next;
  logic [2:0]    seq_pos, seq_pos_next;
  logic [LW-1:0] seq_len, seq_len_next;
  logic          seq_ovf, seq_ovf_next;
  logic          seq_emit, seq_emit_next;

  logic          accept;
  logic          is_dig;
  logic          len_zero;
  logic          act_put;
  logic          act_open;
  logic          act_delim;
  logic          room;
  logic [LW-1:0] put_len;
  logic          put_ovf;
  logic [3:0]    dval;
  logic [19:0]   cnt_x10;
  logic          sat;
  logic [15:0]   put_cnt;
  logic [19:0]   put_bcd;
  logic [15:0]   lit_left_dec;
  logic [2:0]    ndig;
  logic [19:0]   aligned;
  logic [LW-1:0] nd1;
  logic          open_ovf;
  logic [LW-1:0] open_len;
  logic [LW-1:0] aft_len;
  logic          aft_ovf;

  assign in_stall = rst || (state != ST_IDLE) || emit_busy;
  assign accept   = in_valid && !in_stall;
  assign is_dig   = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
  assign len_zero = (tok_len == '0);

  // Decide what the character does; the rules are checked in this order.
  always_comb begin
    act_put   = 1'b0;
    act_open  = 1'b0;
    act_delim = 1'b0;
    if (!halted) begin
      priority if (in_lit) begin
        act_put = 1'b1;
      end else if (is_dig && len_zero) begin
        act_put = 1'b1;
      end else if ((in_char == CHAR_H) && !len_zero && dig_only) begin
        if (cnt > chars_after) begin
          act_put = 1'b1;
        end else begin
          act_open = 1'b1;
        end
      end else if ((in_char == param_delim) || (in_char == record_delim)) begin
        act_delim = 1'b1;
      end else if ((in_char != CHAR_SPACE) || !len_zero) begin
        act_put = 1'b1;
      end
    end
  end

  // Append one character; the running count saturates.
  assign room    = tok_len < TB_LEN;
  assign put_len = room ? tok_len + LW'(1) : tok_len;
  assign put_ovf = ovf || !room;
  assign dval    = in_char[3:0];
  assign cnt_x10 = {1'b0, cnt, 3'b000} + {3'b000, cnt, 1'b0} + {16'h0000, dval};
  assign sat     = |cnt_x10[19:16];
  assign put_cnt = sat ? COUNT_SAT : cnt_x10[15:0];
  assign put_bcd = sat ? BCD_SAT : {bcd[15:0], dval};

  assign lit_left_dec = (lit_left == '0) ? lit_left : lit_left - 16'd1;

  // Significant digits of the count, left-aligned for the rewrite sequence.
  always_comb begin
    priority if (bcd[19:16] != 4'h0) begin
      ndig = 3'd5;
    end else if (bcd[15:12] != 4'h0) begin
      ndig = 3'd4;
    end else if (bcd[11:8] != 4'h0) begin
      ndig = 3'd3;
    end else if (bcd[7:4] != 4'h0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
    unique case (ndig)
      3'd5:    aligned = bcd;
      3'd4:    aligned = {bcd[15:0], 4'h0};
      3'd3:    aligned = {bcd[11:0], 8'h00};
      3'd2:    aligned = {bcd[7:0], 12'h000};
      default: aligned = {bcd[3:0], 16'h0000};
    endcase
  end

  // Rewritten literal header is the digits plus the H, cut to the buffer.
  assign nd1      = LW'(ndig) + LW'(1);
  assign open_ovf = nd1 > TB_LEN;
  assign open_len = open_ovf ? TB_LEN : nd1;

  assign aft_len = act_put ? put_len : tok_len;
  assign aft_ovf = act_put ? put_ovf : ovf;

  // Item processing, literal rewrite sequence and emit requests.
  always_comb begin
    state_next      = state;
    tok_len_next    = tok_len;
    ovf_next        = ovf;
    dig_only_next   = dig_only;
    cnt_next        = cnt;
    bcd_next        = bcd;
    in_lit_next     = in_lit;
    lit_left_next   = lit_left;
    halted_next     = halted;
    seq_digits_next = seq_digits;
    seq_ndig_next   = seq_ndig;
    seq_pos_next    = seq_pos;
    seq_len_next    = seq_len;
    seq_ovf_next    = seq_ovf;
    seq_emit_next   = seq_emit;
    req_valid       = 1'b0;
    req_ctl         = '0;
    req_len         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;

    unique case (state)
      ST_LIT: begin
        // One header character written per cycle, the H last.
        wr_en           = LW'(seq_pos) < TB_LEN;
        wr_addr         = AW'(seq_pos);
        wr_data         = (seq_pos == seq_ndig) ? CHAR_H : CHAR_ZERO + {4'h0, seq_digits[19:16]};
        seq_digits_next = {seq_digits[15:0], 4'h0};
        seq_pos_next    = seq_pos + 3'd1;
        if (seq_pos == seq_ndig) begin
          state_next = ST_IDLE;
          if (seq_emit) begin
            req_valid          = 1'b1;
            req_ctl.burst      = 1'b1;
            req_ctl.token_done = 1'b1;
            req_ctl.data_done  = 1'b1;
            req_ctl.trunc      = seq_ovf;
            req_len            = seq_len;
          end
        end
      end
      default: begin
        if (accept) begin
          if (act_put) begin
            wr_en        = room;
            wr_addr      = tok_len[AW-1:0];
            wr_data      = in_char;
            tok_len_next = put_len;
            ovf_next     = put_ovf;
            if (dig_only) begin
              if (is_dig) begin
                cnt_next = put_cnt;
                bcd_next = put_bcd;
              end else begin
                dig_only_next = 1'b0;
              end
            end
            if (in_lit) begin
              lit_left_next = lit_left_dec;
              in_lit_next   = (lit_left_dec != '0);
            end
          end else if (act_open) begin
            tok_len_next    = open_len;
            ovf_next        = open_ovf;
            dig_only_next   = 1'b0;
            cnt_next        = '0;
            bcd_next        = '0;
            lit_left_next   = cnt;
            in_lit_next     = (cnt != '0);
            state_next      = ST_LIT;
            seq_digits_next = aligned;
            seq_ndig_next   = ndig;
            seq_pos_next    = '0;
            seq_len_next    = open_len;
            seq_ovf_next    = open_ovf;
            seq_emit_next   = final_char;
          end else if (act_delim) begin
            tok_len_next  = '0;
            ovf_next      = 1'b0;
            dig_only_next = 1'b1;
            cnt_next      = '0;
            bcd_next      = '0;
            halted_next   = (in_char == record_delim);
            req_valid          = 1'b1;
            req_ctl.burst      = !len_zero;
            req_ctl.token_done = 1'b1;
            req_ctl.data_done  = final_char;
            req_ctl.trunc      = ovf;
            req_len            = tok_len;
          end

          // End of string: flush a pending token or send the marker, then clear.
          if (final_char) begin
            if (!act_open && !act_delim) begin
              req_valid = 1'b1;
              if (!halted && (aft_len != '0)) begin
                req_ctl.burst      = 1'b1;
                req_ctl.token_done = 1'b1;
                req_ctl.data_done  = 1'b1;
                req_ctl.trunc      = aft_ovf;
                req_len            = aft_len;
              end else begin
                req_ctl.burst      = 1'b0;
                req_ctl.token_done = 1'b0;
                req_ctl.data_done  = 1'b1;
                req_ctl.trunc      = 1'b0;
              end
            end
            tok_len_next  = '0;
            ovf_next      = 1'b0;
            dig_only_next = 1'b1;
            cnt_next      = '0;
            bcd_next      = '0;
            in_lit_next   = 1'b0;
            lit_left_next = '0;
            halted_next   = 1'b0;
          end
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tok_len  <= '0;
      ovf      <= 1'b0;
      dig_only <= 1'b1;
      cnt      <= '0;
      bcd      <= '0;
      in_lit   <= 1'b0;
      lit_left <= '0;
      halted   <= 1'b0;
    end else begin
      state    <= state_next;
      tok_len  <= tok_len_next;
      ovf      <= ovf_next;
      dig_only <= dig_only_next;
      cnt      <= cnt_next;
      bcd      <= bcd_next;
      in_lit   <= in_lit_next;
      lit_left <= lit_left_next;
      halted   <= halted_next;
    end
  end

  // Rewrite sequence registers, only meaningful while in ST_LIT.
  always_ff @(posedge clk) begin
    seq_digits <= seq_digits_next;
    seq_ndig   <= seq_ndig_next;
    seq_pos    <= seq_pos_next;
    seq_len    <= seq_len_next;
    seq_ovf    <= seq_ovf_next;
    seq_emit   <= seq_emit_next;
  end

endmodule

// ----- src/iges_parameter_tokenizer.sv -----
// Channel  | Handshake            | Payload
// input    | in_valid / in_stall  | in_char, chars_after, final_char
// output   | out_valid / out_stall| token_char, char_present, token_done, data_done, truncated
// config   | cfg_we               | cfg_index, cfg_data
//
// An ordinary character does not stall the input. A character that ends a token stalls the
// input until the emitter is done with it: a token is read out of the token store through
// the registered read port, one beat per cycle, and an empty token gives one result with no
// character. Opening a literal writes its count digits and the H into the store one per
// cycle, with the input stalled meanwhile. Output stalls stretch any burst.
// Reset is synchronous; the token store needs no clearing pass and is not cleared.
module iges_parameter_tokenizer import ipt_pkg::*; #(
  parameter int TOKEN_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  input  logic [15:0] chars_after,
  input  logic        final_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  token_char,
  output logic        char_present,
  output logic        token_done,
  output logic        data_done,
  output logic        truncated
);

  localparam int AW = $clog2(TOKEN_BYTES);
  localparam int LW = $clog2(TOKEN_BYTES + 1);

  logic [7:0]    param_delim;
  logic [7:0]    record_delim;
  logic          emit_busy;
  logic          req_valid;
  emit_ctl_t     req_ctl;
  logic [LW-1:0] req_len;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Delimiter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      param_delim  <= PARAM_DELIM_RST;
      record_delim <= RECORD_DELIM_RST;
    end else if (cfg_we) begin
      if (cfg_reg_t'(cfg_index) == REG_PARAM_DELIM) begin
        param_delim <= cfg_data;
      end else begin
        record_delim <= cfg_data;
      end
    end
  end

  ipt_parser #(
    .TOKEN_BYTES (TOKEN_BYTES),
    .AW          (AW),
    .LW          (LW)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .param_delim  (param_delim),
    .record_delim (record_delim),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .chars_after  (chars_after),
    .final_char   (final_char),
    .emit_busy    (emit_busy),
    .req_valid    (req_valid),
    .req_ctl      (req_ctl),
    .req_len      (req_len),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  ipt_token_store #(
    .DEPTH (TOKEN_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ipt_emit #(
    .AW (AW),
    .LW (LW)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ctl      (req_ctl),
    .req_len      (req_len),
    .busy         (emit_busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_char   (token_char),
    .char_present (char_present),
    .token_done   (token_done),
    .data_done    (data_done),
    .truncated    (truncated)
  );

endmodule
